// File: sv/ufss_pkg.sv
package ufss_pkg;

   localparam int NODES_DEFAULT = 1024;
   localparam int NODE_IN_W     = 10;
   localparam int RANK_W        = 4;
   localparam int SIZE_W        = 11;

   localparam logic [RANK_W-1:0] RANK_MAX = '1;
   localparam logic [SIZE_W-1:0] SIZE_MAX = '1;
   localparam logic [SIZE_W-1:0] SIZE_ONE = SIZE_W'(1);

   localparam logic CMD_UNITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef struct packed {
      logic en;
      logic we;
   } mem_ctl_type;

endpackage

// File: sv/ufss_mem.sv
module ufss_mem #(
   parameter int DEPTH = ufss_pkg::NODES_DEFAULT,
   parameter int WIDTH = 25
) (
   input  logic                     clock,
   input  ufss_pkg::mem_ctl_type    ctl,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (ctl.en) begin
         if (ctl.we) begin
            mem[addr] <= wdata;
         end else begin
            rdata_ff <= mem[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: sv/ufss_ctrl.sv
module ufss_ctrl #(
   parameter int NODES = ufss_pkg::NODES_DEFAULT,
   parameter int NW    = $clog2(NODES),
   parameter int W     = NW + ufss_pkg::RANK_W + ufss_pkg::SIZE_W
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_command,
   input  logic [NW-1:0]                       node_a,
   input  logic [NW-1:0]                       node_b,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [NW-1:0]                       rsp_root,
   output logic [ufss_pkg::SIZE_W-1:0]         rsp_set_size,
   output logic                                rsp_were_same,
   output ufss_pkg::mem_ctl_type               mem_ctl,
   output logic [NW-1:0]                       mem_addr,
   output logic [W-1:0]                        mem_wdata,
   input  logic [W-1:0]                        mem_rdata
);

   localparam int RW = ufss_pkg::RANK_W;
   localparam int SW = ufss_pkg::SIZE_W;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_FIND_RD, ST_FIND_CHK, ST_COMP_RD, ST_COMP_WR,
      ST_LINK_LO, ST_LINK_HI, ST_DONE
   } state_type;

   state_type   state_ff;
   logic [NW-1:0] clr_ff;
   logic          cmd_ff, side_ff;
   logic [NW-1:0] a_ff, b_ff, cur_ff, root_ff, ra_ff, rb_ff;
   logic [RW-1:0] rank_ra_ff, rank_rb_ff;
   logic [SW-1:0] size_ra_ff, size_rb_ff;
   logic          rsp_valid_ff, rsp_same_ff;
   logic [NW-1:0] rsp_root_ff;
   logic [SW-1:0] rsp_size_ff;

   logic [NW-1:0] rd_parent;
   logic [RW-1:0] rd_rank;
   logic [SW-1:0] rd_size;
   logic          do_union, b_under_a;
   logic [NW-1:0] keep, lose;
   logic [SW:0]   sum_wide;
   logic [SW-1:0] sum;
   logic [RW-1:0] keep_rank;
   logic          rsp_load;

   assign rd_parent = mem_rdata[W-1 -: NW];
   assign rd_rank   = mem_rdata[SW +: RW];
   assign rd_size   = mem_rdata[SW-1:0];

   assign do_union  = (cmd_ff == ufss_pkg::CMD_UNITE) && (ra_ff != rb_ff);
   assign b_under_a = !(rank_ra_ff < rank_rb_ff);
   assign keep      = b_under_a ? ra_ff : rb_ff;
   assign lose      = b_under_a ? rb_ff : ra_ff;
   assign sum_wide  = {1'b0, size_ra_ff} + {1'b0, size_rb_ff};
   assign sum       = sum_wide[SW] ? ufss_pkg::SIZE_MAX : sum_wide[SW-1:0];

   always_comb begin
      if (!b_under_a) begin
         keep_rank = rank_rb_ff;
      end else if (rank_ra_ff == rank_rb_ff && rank_ra_ff != ufss_pkg::RANK_MAX) begin
         keep_rank = rank_ra_ff + RW'(1);
      end else begin
         keep_rank = rank_ra_ff;
      end
   end

   // single memory port
   always_comb begin
      mem_ctl   = '0;
      mem_addr  = cur_ff;
      mem_wdata = {rd_parent, rd_rank, rd_size};
      unique case (state_ff)
         ST_CLEAR: begin
            mem_ctl   = '{en: 1'b1, we: 1'b1};
            mem_addr  = clr_ff;
            mem_wdata = {clr_ff, RW'(0), ufss_pkg::SIZE_ONE};
         end
         ST_FIND_RD: begin
            mem_ctl = '{en: 1'b1, we: 1'b0};
         end
         ST_COMP_RD: begin
            mem_ctl = '{en: cur_ff != root_ff, we: 1'b0};
         end
         ST_COMP_WR: begin
            mem_ctl   = '{en: 1'b1, we: 1'b1};
            mem_wdata = {root_ff, rd_rank, rd_size};
         end
         ST_LINK_LO: begin
            mem_ctl   = '{en: 1'b1, we: 1'b1};
            mem_addr  = lose;
            mem_wdata = b_under_a ? {ra_ff, rank_rb_ff, size_rb_ff}
                                  : {rb_ff, rank_ra_ff, size_ra_ff};
         end
         ST_LINK_HI: begin
            mem_ctl   = '{en: 1'b1, we: 1'b1};
            mem_addr  = keep;
            mem_wdata = {keep, keep_rank, sum};
         end
         default: begin
         end
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_load  = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
            rsp_root_ff  <= do_union ? keep : ra_ff;
            rsp_size_ff  <= do_union ? sum : size_ra_ff;
            rsp_same_ff  <= (ra_ff == rb_ff);
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_CLEAR: begin
               if (clr_ff == NW'(NODES - 1)) begin
                  state_ff <= ST_IDLE;
               end else begin
                  clr_ff <= clr_ff + NW'(1);
               end
            end
            ST_IDLE: begin
               if (req_valid) begin
                  cmd_ff   <= req_command;
                  a_ff     <= node_a;
                  b_ff     <= node_b;
                  cur_ff   <= node_a;
                  side_ff  <= 1'b0;
                  state_ff <= ST_FIND_RD;
               end
            end
            ST_FIND_RD: begin
               state_ff <= ST_FIND_CHK;
            end
            ST_FIND_CHK: begin
               if (rd_parent == cur_ff) begin
                  root_ff <= cur_ff;
                  if (!side_ff) begin
                     ra_ff      <= cur_ff;
                     rank_ra_ff <= rd_rank;
                     size_ra_ff <= rd_size;
                     cur_ff     <= a_ff;
                  end else begin
                     rb_ff      <= cur_ff;
                     rank_rb_ff <= rd_rank;
                     size_rb_ff <= rd_size;
                     cur_ff     <= b_ff;
                  end
                  state_ff <= ST_COMP_RD;
               end else begin
                  cur_ff   <= rd_parent;
                  state_ff <= ST_FIND_RD;
               end
            end
            ST_COMP_RD: begin
               if (cur_ff != root_ff) begin
                  state_ff <= ST_COMP_WR;
               end else if (!side_ff) begin
                  side_ff  <= 1'b1;
                  cur_ff   <= b_ff;
                  state_ff <= ST_FIND_RD;
               end else begin
                  state_ff <= do_union ? ST_LINK_LO : ST_DONE;
               end
            end
            ST_COMP_WR: begin
               cur_ff   <= rd_parent;
               state_ff <= ST_COMP_RD;
            end
            ST_LINK_LO: begin
               state_ff <= ST_LINK_HI;
            end
            ST_LINK_HI: begin
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               if (rsp_load) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_root      = rsp_root_ff;
   assign rsp_set_size  = rsp_size_ff;
   assign rsp_were_same = rsp_same_ff;

endmodule

// File: sv/union_find_set_sizes.sv
// Disjoint-set engine: every item finds the roots of node_a and node_b with full path
// compression, a unite item then links the lower-rank root under the other, and one result
// gives node_a's root, its set size and whether a and b already shared a set. All state
// (parent, rank, size per node) sits in one single-port memory, so an item is handled
// step by step: each root walk reads and checks every node on its path, then rewrites each
// non-root node on that path with the root as parent (b's walk runs after a's path is
// compressed); a real union adds two link writes, the lower root's and the kept root's, and
// a stalled result holds the engine until it transfers. No new item is taken until the last
// one's result is loaded. After reset a clearing pass initialises every memory entry;
// req_stall stays high throughout. Indices at or above NODES are saturated to NODES-1.
module union_find_set_sizes #(
   parameter int NODES = ufss_pkg::NODES_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_command,
   input  logic [ufss_pkg::NODE_IN_W-1:0]    req_node_a,
   input  logic [ufss_pkg::NODE_IN_W-1:0]    req_node_b,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [ufss_pkg::NODE_IN_W-1:0]    rsp_root,
   output logic [ufss_pkg::SIZE_W-1:0]       rsp_set_size,
   output logic                              rsp_were_same
);

   localparam int NW = $clog2(NODES);
   localparam int W  = NW + ufss_pkg::RANK_W + ufss_pkg::SIZE_W;

   logic [NW-1:0]         node_a, node_b, root;
   ufss_pkg::mem_ctl_type mem_ctl;
   logic [NW-1:0]         mem_addr;
   logic [W-1:0]          mem_wdata, mem_rdata;

   always_comb begin
      node_a = (32'(req_node_a) >= NODES) ? NW'(NODES - 1) : NW'(32'(req_node_a));
      node_b = (32'(req_node_b) >= NODES) ? NW'(NODES - 1) : NW'(32'(req_node_b));
   end

   ufss_ctrl #(.NODES(NODES), .NW(NW), .W(W)) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_command   (req_command),
      .node_a        (node_a),
      .node_b        (node_b),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_root      (root),
      .rsp_set_size  (rsp_set_size),
      .rsp_were_same (rsp_were_same),
      .mem_ctl       (mem_ctl),
      .mem_addr      (mem_addr),
      .mem_wdata     (mem_wdata),
      .mem_rdata     (mem_rdata)
   );

   ufss_mem #(.DEPTH(NODES), .WIDTH(W)) u_mem (
      .clock (clock),
      .ctl   (mem_ctl),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   // roots only ever come from addressable nodes
   assign rsp_root = ufss_pkg::NODE_IN_W'(32'(root));

endmodule

// File: sv/ufss_checker.sv
module ufss_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [ufss_pkg::NODE_IN_W-1:0]    rsp_root,
   input logic [ufss_pkg::SIZE_W-1:0]       rsp_set_size,
   input logic                              rsp_were_same
);

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid && req_stall)
      else $error("response or intake active after reset");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second item taken while one is in work");

   a_size_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_set_size != '0)
      else $error("empty set reported");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_root)
         && $stable(rsp_set_size) && $stable(rsp_were_same))
      else $error("stalled response changed");

endmodule

bind union_find_set_sizes ufss_checker u_ufss_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_root      (rsp_root),
   .rsp_set_size  (rsp_set_size),
   .rsp_were_same (rsp_were_same)
);

// File: tb/union_find_set_sizes_tb.sv
module union_find_set_sizes_tb;

   localparam int N = ufss_pkg::NODES_DEFAULT;
   localparam int ROWS = 14;

   typedef struct packed {
      logic             cmd;
      logic [9:0]       a;
      logic [9:0]       b;
      logic             known;
      logic [9:0]       root;
      logic [10:0]      size;
      logic             same;
   } row_type;

   typedef struct packed {
      logic [9:0]  root;
      logic [10:0] size;
      logic        same;
   } answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_command = ufss_pkg::CMD_QUERY;
   logic [9:0] req_node_a = '0;
   logic [9:0] req_node_b = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [9:0] rsp_root;
   logic [10:0] rsp_set_size;
   logic rsp_were_same;

   // shadow disjoint-set state
   logic [9:0]  parent_q [N];
   logic [3:0]  rank_q [N];
   logic [10:0] size_q [N];
   answer_type answers_due [$];
   int fails = 0;
   bit sending = 1'b0;

   union_find_set_sizes uut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [9:0] root_of(input logic [9:0] x);
      logic [9:0] r;
      logic [9:0] nx;
      r = x;
      while (parent_q[r] != r) r = parent_q[r];
      while (x != r) begin
         nx = parent_q[x];
         parent_q[x] = r;
         x = nx;
      end
      return r;
   endfunction

   function automatic answer_type apply_item(input logic cmd, input logic [9:0] a,
                                             input logic [9:0] b);
      logic [9:0] ra;
      logic [9:0] rb;
      logic [9:0] keep;
      logic [11:0] sum;
      answer_type ans;
      ra = root_of(a);
      rb = root_of(b);
      ans.same = (ra == rb);
      if (cmd == ufss_pkg::CMD_UNITE && !ans.same) begin
         if (rank_q[ra] < rank_q[rb]) begin
            parent_q[ra] = rb;
            keep = rb;
         end else begin
            parent_q[rb] = ra;
            keep = ra;
            if (rank_q[ra] == rank_q[rb] && rank_q[ra] != ufss_pkg::RANK_MAX)
               rank_q[ra] = 4'(rank_q[ra] + 4'd1);
         end
         sum = {1'b0, size_q[ra]} + {1'b0, size_q[rb]};
         size_q[keep] = (sum > 12'(ufss_pkg::SIZE_MAX)) ? ufss_pkg::SIZE_MAX : sum[10:0];
      end
      ans.root = root_of(a);
      ans.size = size_q[ans.root];
      return ans;
   endfunction

   task automatic send(input logic cmd, input logic [9:0] a, input logic [9:0] b);
      req_valid   <= 1'b1;
      req_command <= cmd;
      req_node_a  <= a;
      req_node_b  <= b;
      do @(posedge clock); while (req_stall);
      answers_due = {answers_due, apply_item(cmd, a, b)};
   endtask

   task automatic idle(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // receiver: stalls in its own pattern, with calm stretches
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (answers_due.size() == 0) begin
               $error("unexpected transfer: root %0d", rsp_root);
               fails++;
            end else begin
               answer_type e;
               e = answers_due.pop_front();
               if (rsp_root !== e.root) begin
                  $error("root: expected %0d, got %0d", e.root, rsp_root);
                  fails++;
               end
               if (rsp_set_size !== e.size) begin
                  $error("set_size: expected %0d, got %0d", e.size, rsp_set_size);
                  fails++;
               end
               if (rsp_were_same !== e.same) begin
                  $error("were_same: expected %0d, got %0d", e.same, rsp_were_same);
                  fails++;
               end
            end
         end
         if ($urandom_range(0, 255) < 8) rsp_stall <= 1'b0;
         else if ($urandom_range(0, 63) == 0) rsp_stall <= 1'b1;
         else if (rsp_stall) rsp_stall <= ($urandom_range(0, 3) != 0);
         else rsp_stall <= ($urandom_range(0, 9) < 2) && sending;
      end
   end

   initial begin
      row_type rows [ROWS];
      row_type r;
      answer_type got;
      int burst;
      int sub;
      int base;
      logic [9:0] x;
      logic [9:0] y;
      for (int i = 0; i < N; i++) begin
         parent_q[i] = 10'(i);
         rank_q[i] = '0;
         size_q[i] = ufss_pkg::SIZE_ONE;
      end
      // directed: after reset, extremes, unite within one set, chain building
      rows = '{
         '{ufss_pkg::CMD_QUERY, 10'd0,    10'd1023, 1'b1, 10'd0,    11'd1, 1'b0},
         '{ufss_pkg::CMD_QUERY, 10'd1023, 10'd1023, 1'b1, 10'd1023, 11'd1, 1'b1},
         '{ufss_pkg::CMD_UNITE, 10'd0,    10'd1023, 1'b1, 10'd0,    11'd2, 1'b0},
         '{ufss_pkg::CMD_UNITE, 10'd1023, 10'd0,    1'b1, 10'd0,    11'd2, 1'b1},
         '{ufss_pkg::CMD_UNITE, 10'd5,    10'd5,    1'b1, 10'd5,    11'd1, 1'b1},
         '{ufss_pkg::CMD_UNITE, 10'd2,    10'd3,    1'b0, 10'd0, 11'd0, 1'b0},
         '{ufss_pkg::CMD_UNITE, 10'd3,    10'd0,    1'b0, 10'd0, 11'd0, 1'b0},
         '{ufss_pkg::CMD_UNITE, 10'd682,  10'd341,  1'b0, 10'd0, 11'd0, 1'b0},
         '{ufss_pkg::CMD_UNITE, 10'd341,  10'd1023, 1'b0, 10'd0, 11'd0, 1'b0},
         '{ufss_pkg::CMD_QUERY, 10'd682,  10'd2,    1'b0, 10'd0, 11'd0, 1'b0},
         '{ufss_pkg::CMD_QUERY, 10'd512,  10'd511,  1'b0, 10'd0, 11'd0, 1'b0},
         '{ufss_pkg::CMD_UNITE, 10'd512,  10'd511,  1'b0, 10'd0, 11'd0, 1'b0},
         '{ufss_pkg::CMD_UNITE, 10'd1,    10'd512,  1'b0, 10'd0, 11'd0, 1'b0},
         '{ufss_pkg::CMD_QUERY, 10'd511,  10'd1,    1'b0, 10'd0, 11'd0, 1'b0}
      };
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      foreach (rows[i]) begin
         r = rows[i];
         send(r.cmd, r.a, r.b);
         if (r.known) begin
            got = answers_due[$];
            if (got != {r.root, r.size, r.same}) begin
               $error("table row %0d: expected %h, predictor %h", i,
                      {r.root, r.size, r.same}, got);
               fails++;
            end
         end
      end
      sending = 1'b1;
      // random: mostly unites inside a moving window so sets grow deep
      for (int n = 0; n < 1600; n += burst) begin
         burst = $urandom_range(1, 24);
         base = $urandom_range(0, N - 1);
         sub = $urandom_range(3, 200);
         for (int k = 0; k < burst; k++) begin
            x = 10'(base + $urandom_range(0, sub));
            y = ($urandom_range(0, 9) == 0) ? 10'($urandom)
                                            : 10'(base + $urandom_range(0, sub));
            send(($urandom_range(0, 9) < 6) ? ufss_pkg::CMD_UNITE : ufss_pkg::CMD_QUERY,
                 x, y);
         end
         if (n > 800 && n < 830) begin
            // hold off until drained
            req_valid <= 1'b0;
            while (answers_due.size() != 0) @(posedge clock);
         end
         if ($urandom_range(0, 2) != 0) idle($urandom_range(1, 40));
      end
      req_valid <= 1'b0;
      sending = 1'b0;
      while (answers_due.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fails == 0) $display("union_find_set_sizes_tb: PASS");
      else $display("union_find_set_sizes_tb: FAIL");
      $finish;
   end

   initial begin
      #40000000;
      $display("union_find_set_sizes_tb: FAIL");
      $finish;
   end

endmodule

// File: files.f
sv/ufss_pkg.sv
sv/ufss_mem.sv
sv/ufss_ctrl.sv
sv/union_find_set_sizes.sv
sv/ufss_checker.sv
tb/union_find_set_sizes_tb.sv
